@@ rtl/core/ile_pkg.sv @@
// ile_pkg: opcode and status codes, the read-miss word, and the
// command/flag structs shared by the list engine controller and datapath
// no dependencies
package ile_pkg;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // word returned by a read outside the list
  localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;

  typedef struct packed {
    logic    load_in;
    logic    decode;
    status_t st;
    logic    rd_issue;
    logic    shift_start;
    logic    shift_up;
    logic    shift_step;
    logic    put;
    logic    finish;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    tgt_gt_cnt;
    logic    tgt_lt_cnt;
    logic    tgt_p1_lt_cnt;
    logic    full;
    logic    last_step;
    logic    out_free;
  } dp_flags_t;

endpackage

@@ rtl/core/ile_ctrl.sv @@
// ile_ctrl: sequencer for the list engine, one request at a time
// depends on ile_pkg for the command/flag structs and codes
module ile_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ile_pkg::dp_flags_t  flags,
  output ile_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_PUT    = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.st     = ile_pkg::ST_DONE;
    in_stall   = 1'b1;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_RESP;
        unique case (flags.op) inside
          ile_pkg::OP_READ: begin
            if (flags.tgt_lt_cnt) begin
              cmd.rd_issue = 1'b1;
            end else begin
              cmd.st = ile_pkg::ST_RANGE;
            end
          end
          ile_pkg::OP_INS_HEAD, ile_pkg::OP_INS_TAIL, ile_pkg::OP_INS_AT: begin
            if (flags.tgt_gt_cnt) begin
              cmd.st = ile_pkg::ST_RANGE;
            end else if (flags.full) begin
              cmd.st = ile_pkg::ST_FULL;
            end else if (flags.tgt_lt_cnt) begin
              cmd.shift_start = 1'b1;
              cmd.shift_up    = 1'b1;
              state_next      = S_SHIFT;
            end else begin
              state_next = S_PUT;
            end
          end
          ile_pkg::OP_DELETE: begin
            if (!flags.tgt_lt_cnt) begin
              cmd.st = ile_pkg::ST_RANGE;
            end else if (flags.tgt_p1_lt_cnt) begin
              cmd.shift_start = 1'b1;
              state_next      = S_SHIFT;
            end
          end
          default: begin
            cmd.st = ile_pkg::ST_DONE;
          end
        endcase
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (flags.last_step) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (flags.op == ile_pkg::OP_DELETE) begin
          state_next = S_RESP;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (flags.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/ile_datapath.sv @@
// ile_datapath: request registers, entry count, entry memory with
// pipelined one-entry-per-cycle shifting, and the result register
// depends on ile_pkg for codes, the read-miss word and the command/flag structs
module ile_datapath #(
  parameter  int CAPACITY   = 1024,
  parameter  int DATA_WIDTH = 32,
  localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ile_pkg::dp_cmd_t       cmd,
  output ile_pkg::dp_flags_t     flags,
  input  logic [2:0]             opcode,
  input  logic [15:0]            position,
  input  logic signed [31:0]     value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     read_value,
  output logic [1:0]             status,
  output logic [CNT_W-1:0]       entry_count
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > 16) ? CNT_W : 16;

  ile_pkg::opcode_t     op_q;
  logic [15:0]          pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [CNT_W-1:0]     tgt;
  logic [CNT_W-1:0]     ptr;
  logic [CNT_W-1:0]     src;
  logic                 dir_up;
  logic                 wr_pend;
  logic [ADDR_W-1:0]    wdst;
  ile_pkg::status_t     st_q;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [CMP_W-1:0]     cnt_w;
  logic [CMP_W-1:0]     tgt_w;
  logic [CMP_W:0]       tgt_p1;
  logic [CNT_W-1:0]     tgt_inc;
  logic [CNT_W:0]       ptr_p2;
  logic [ADDR_W-1:0]    raddr;
  logic                 rd_en;
  logic signed [63:0]   val64;
  logic signed [63:0]   rd64;
  logic [31:0]          rv;

  assign val64 = 64'(value);
  assign rd64  = 64'(signed'(rd_data));

  // target index of the request
  always_comb begin
    cnt_w = CMP_W'(count);
    case (op_q)
      ile_pkg::OP_INS_HEAD: tgt_w = '0;
      ile_pkg::OP_INS_TAIL: tgt_w = cnt_w;
      default:              tgt_w = CMP_W'(pos_q);
    endcase
  end

  assign tgt_p1  = (CMP_W + 1)'(tgt_w) + (CMP_W + 1)'(1);
  assign tgt_inc = tgt + CNT_W'(1);
  assign ptr_p2  = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(2);
  assign src     = dir_up ? (ptr - CNT_W'(1)) : (ptr + CNT_W'(1));
  assign raddr   = cmd.decode ? tgt_w[ADDR_W-1:0] : src[ADDR_W-1:0];
  assign rd_en   = cmd.rd_issue || cmd.shift_step;

  always_comb begin
    flags.op            = op_q;
    flags.tgt_gt_cnt    = tgt_w > cnt_w;
    flags.tgt_lt_cnt    = tgt_w < cnt_w;
    flags.tgt_p1_lt_cnt = tgt_p1 < (CMP_W + 1)'(cnt_w);
    flags.full          = count == CNT_W'(CAPACITY);
    flags.last_step     = dir_up ? (ptr == tgt_inc) : (ptr_p2 == (CNT_W + 1)'(count));
    flags.out_free      = !out_valid || !out_stall;
  end

  always_comb begin
    count_next = count;
    if (st_q == ile_pkg::ST_DONE) begin
      case (op_q) inside
        ile_pkg::OP_INS_HEAD, ile_pkg::OP_INS_TAIL, ile_pkg::OP_INS_AT:
          count_next = count + CNT_W'(1);
        ile_pkg::OP_DELETE:
          count_next = count - CNT_W'(1);
        default:
          count_next = count;
      endcase
    end
  end

  always_comb begin
    if (op_q == ile_pkg::OP_READ) begin
      rv = (st_q == ile_pkg::ST_DONE) ? rd64[31:0] : ile_pkg::READ_MISS;
    end else begin
      rv = '0;
    end
  end

  // request and sequencing registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q  <= ile_pkg::opcode_t'(opcode);
      pos_q <= position;
      val_q <= val64[DATA_WIDTH-1:0];
    end
    if (cmd.decode) begin
      tgt  <= tgt_w[CNT_W-1:0];
      st_q <= cmd.st;
    end
    if (cmd.shift_start) begin
      dir_up <= cmd.shift_up;
      ptr    <= cmd.shift_up ? count : tgt_w[CNT_W-1:0];
    end else if (cmd.shift_step) begin
      ptr <= src;
    end
    if (cmd.shift_step) begin
      wdst <= ptr[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.shift_step;
    end
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_pend) begin
      mem[wdst] <= rd_data;
    end else if (cmd.put) begin
      mem[tgt[ADDR_W-1:0]] <= val_q;
    end
    if (rd_en) begin
      rd_data <= mem[raddr];
    end
  end

  // count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_value  <= rv;
      status      <= st_q;
      entry_count <= count_next;
    end
  end

endmodule

@@ rtl/core/indexed_list_engine.sv @@
// indexed_list_engine: ordered list of up to CAPACITY signed words in one memory
// insert/delete move n entries, n <= CAPACITY - 1, one entry a cycle
// through the single write port of the entry memory; one request in flight
// reset: clears entry count, sequencer and result valid; store is not cleared
// depends on ile_pkg, ile_ctrl and ile_datapath
module indexed_list_engine #(
  parameter  int CAPACITY   = 1024,
  parameter  int DATA_WIDTH = 32,
  localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  // request word
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          opcode,
  input  logic [15:0]         position,
  input  logic signed [31:0]  value,
  // result word
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  read_value,
  output logic [1:0]          status,
  output logic [CNT_W-1:0]    entry_count
);

  // command and flag groups between sequencer and datapath
  ile_pkg::dp_cmd_t   cmd;
  ile_pkg::dp_flags_t flags;

  // sequencer: takes a word only when idle, walks the decode, shift,
  // drain, put and respond steps; a response waits in RESP while the
  // result register still holds an untaken word
  ile_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .flags    (flags),
    .cmd      (cmd)
  );

  // datapath: range and capacity checks, entry memory with a pipelined
  // read-then-write shift, count update and the result register
  ile_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .flags       (flags),
    .opcode      (opcode),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule
